/* sv/colt_pkg.sv */
// Shared constants for the columnar transposition block.
// Used by columnar_transposition and its testbench; no dependencies.
package colt_pkg;

  localparam int MAX_BYTES_DEF   = 64;
  localparam int MAX_COLUMNS_DEF = 16;

  localparam int BYTE_W    = 8;
  localparam int KEYLEN_W  = 5;
  localparam int RANK_BITS = 4;
  localparam int RANK_W    = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_RANK = 2'd2;

  localparam logic              DIR_ENCRYPT    = 1'b0;
  localparam logic              DIR_DECRYPT    = 1'b1;
  localparam logic [KEYLEN_W-1:0] KEYLEN_RESET = 5'd16;
  localparam logic [RANK_W-1:0] RANK_RESET     = 64'hFEDC_BA98_7654_3210;

  localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

endpackage

/* sv/colt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; read data holds until the next read request.
module colt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/columnar_transposition.sv */
// Columnar transposition: buffers one message, then emits it transposed.
// After the last request: CNT_W divide steps, L setup steps (L = column count), then one RAM
// read stage into the output register; encrypting adds a seek step at each column.
// Load: one request per cycle; input is held off from the last request to the last read.
// Emission: one byte per cycle unless out_tready stalls; empty encrypt columns add a step.
// Reset: synchronous active-low rst_n clears counters and handshakes and sets identity order,
// 16 columns, encrypt. Depends on colt_pkg and colt_ram.
module columnar_transposition #(
  parameter int MAX_BYTES   = colt_pkg::MAX_BYTES_DEF,
  parameter int MAX_COLUMNS = colt_pkg::MAX_COLUMNS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [colt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [colt_pkg::RANK_W-1:0]       cfg_data,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [colt_pkg::BYTE_W-1:0]       in_tdata,   // [7:0] data_byte
  input  logic                              in_tlast,   // last_in
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [colt_pkg::BYTE_W-1:0]       out_tdata,  // [7:0] out_byte
  output logic                              out_tlast,  // last_out
  output logic                              out_tuser   // [0] dropped
);

  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int ADDR_W    = $clog2(MAX_BYTES);
  localparam int COL_W     = $clog2(MAX_COLUMNS + 1);
  localparam int COL_IDX_W = $clog2(MAX_COLUMNS);
  localparam int DIV_W     = (CNT_W > 1) ? $clog2(CNT_W) : 1;
  localparam int BW        = colt_pkg::BYTE_W;
  localparam int RB        = colt_pkg::RANK_BITS;

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_SETUP = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t                         state_r;
  logic                           dir_r;
  logic [colt_pkg::KEYLEN_W-1:0]  keylen_r;
  logic [colt_pkg::RANK_W-1:0]    rank_r;

  logic [CNT_W-1:0]     cnt_r;
  logic                 ovf_r;
  logic [CNT_W-1:0]     n_r;
  logic                 drop_r;

  logic [DIV_W-1:0]     div_i_r;
  logic [CNT_W-1:0]     div_q_r;
  logic [COL_W-1:0]     div_rem_r;

  logic [COL_IDX_W-1:0] setup_c_r;
  logic [COL_IDX_W-1:0] order_r [MAX_COLUMNS];
  logic [CNT_W-1:0]     start_r [MAX_COLUMNS];

  logic [CNT_W-1:0]     k_r;
  logic                 seek_r;
  logic [COL_IDX_W-1:0] oi_r;
  logic [CNT_W:0]       enc_addr_r;
  logic [COL_IDX_W-1:0] dc_r;
  logic [CNT_W-1:0]     dr_r;

  logic                 pend_r;
  logic                 pend_last_r;
  logic                 pend_drop_r;
  logic                 out_valid_r;
  logic [BW-1:0]        out_byte_r;
  logic                 out_last_r;
  logic                 out_drop_r;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r    <= colt_pkg::DIR_ENCRYPT;
      keylen_r <= colt_pkg::KEYLEN_RESET;
      rank_r   <= colt_pkg::RANK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        colt_pkg::REG_DIRECTION:   dir_r    <= cfg_data[0];
        colt_pkg::REG_KEY_LENGTH:  keylen_r <= cfg_data[colt_pkg::KEYLEN_W-1:0];
        colt_pkg::REG_COLUMN_RANK: rank_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective column count
  logic [COL_W-1:0] l_eff;
  always_comb begin
    if (keylen_r == '0) begin
      l_eff = COL_W'(1);
    end else if (keylen_r > colt_pkg::KEYLEN_W'(MAX_COLUMNS)) begin
      l_eff = COL_W'(MAX_COLUMNS);
    end else begin
      l_eff = keylen_r[COL_W-1:0];
    end
  end

  // load side
  logic in_acc;
  logic stored;
  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign stored    = cnt_r < CNT_W'(MAX_BYTES);

  // divider step
  logic [COL_W:0] div_trial;
  logic [COL_W:0] div_diff;
  logic           div_ge;
  assign div_trial = {div_rem_r, n_r[div_i_r]};
  assign div_ge    = div_trial >= {1'b0, l_eff};
  assign div_diff  = div_trial - {1'b0, l_eff};

  // setup: rank position and start offset of column setup_c_r
  logic [RB-1:0]          rank_c;
  logic [MAX_COLUMNS-1:0] pred;
  logic [MAX_COLUMNS-1:0] pred_rem;
  logic [COL_W-1:0]       pos_cnt;
  logic [COL_W-1:0]       rem_cnt;
  logic [CNT_W+COL_W-1:0] start_full;
  logic [CNT_W-1:0]       start_c;

  assign rank_c = rank_r[setup_c_r*RB +: RB];

  always_comb begin
    for (int j = 0; j < MAX_COLUMNS; j++) begin
      pred[j] = (COL_W'(j) < l_eff) &&
                ((rank_r[j*RB +: RB] < rank_c) ||
                 ((rank_r[j*RB +: RB] == rank_c) && (COL_IDX_W'(j) < setup_c_r)));
      pred_rem[j] = pred[j] && (COL_W'(j) < div_rem_r);
    end
  end

  assign pos_cnt    = COL_W'($countones(pred));
  assign rem_cnt    = COL_W'($countones(pred_rem));
  assign start_full = div_q_r * pos_cnt + (CNT_W+COL_W)'(rem_cnt);
  assign start_c    = start_full[CNT_W-1:0];

  // emission
  logic              move;
  logic              emit_go;
  logic              issue;
  logic              is_last;
  logic              enc_live;
  logic [CNT_W:0]    enc_next;
  logic [CNT_W-1:0]  dec_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [BW-1:0]     rd_data;
  logic [BW-1:0]     fold_byte;

  assign move     = pend_r && (!out_valid_r || out_tready);
  assign emit_go  = (state_r == ST_EMIT) && (!pend_r || move);
  assign enc_live = !seek_r && (enc_addr_r < {1'b0, n_r});
  assign issue    = emit_go && (dir_r || enc_live);
  assign is_last  = (k_r == n_r - CNT_W'(1));
  assign enc_next = enc_addr_r + (CNT_W+1)'(l_eff);
  assign dec_addr = start_r[dc_r] + dr_r;
  assign rd_addr  = dir_r ? dec_addr[ADDR_W-1:0] : enc_addr_r[ADDR_W-1:0];

  colt_ram #(
    .WIDTH (BW),
    .DEPTH (MAX_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (in_acc && stored),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (in_tdata),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    fold_byte = rd_data;
    if (dir_r == colt_pkg::DIR_ENCRYPT && rd_data >= colt_pkg::CHAR_UPPER_A &&
        rd_data <= colt_pkg::CHAR_UPPER_Z) begin
      fold_byte = rd_data + colt_pkg::CASE_OFFSET;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (in_tlast) begin
              n_r       <= stored ? cnt_r + CNT_W'(1) : cnt_r;
              drop_r    <= ovf_r || !stored;
              cnt_r     <= '0;
              ovf_r     <= 1'b0;
              div_i_r   <= DIV_W'(CNT_W - 1);
              div_q_r   <= '0;
              div_rem_r <= '0;
              state_r   <= ST_DIV;
            end else if (stored) begin
              cnt_r <= cnt_r + CNT_W'(1);
            end else begin
              ovf_r <= 1'b1;
            end
          end
        end
        ST_DIV: begin
          div_q_r   <= {div_q_r[CNT_W-2:0], div_ge};
          div_rem_r <= div_ge ? div_diff[COL_W-1:0] : div_trial[COL_W-1:0];
          div_i_r   <= div_i_r - DIV_W'(1);
          if (div_i_r == '0) begin
            setup_c_r <= '0;
            state_r   <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          order_r[pos_cnt[COL_IDX_W-1:0]] <= setup_c_r;
          start_r[setup_c_r]              <= start_c;
          setup_c_r                       <= setup_c_r + COL_IDX_W'(1);
          if (COL_W'(setup_c_r) == l_eff - COL_W'(1)) begin
            k_r     <= '0;
            seek_r  <= 1'b1;
            oi_r    <= '0;
            dc_r    <= '0;
            dr_r    <= '0;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (dir_r == colt_pkg::DIR_ENCRYPT) begin
            if (seek_r) begin
              enc_addr_r <= (CNT_W+1)'(order_r[oi_r]);
              seek_r     <= 1'b0;
            end else if (!enc_live) begin
              oi_r   <= oi_r + COL_IDX_W'(1);
              seek_r <= 1'b1;
            end else if (issue) begin
              if (enc_next >= {1'b0, n_r}) begin
                oi_r   <= oi_r + COL_IDX_W'(1);
                seek_r <= 1'b1;
              end else begin
                enc_addr_r <= enc_next;
              end
            end
          end else if (issue) begin
            if (COL_W'(dc_r) == l_eff - COL_W'(1)) begin
              dc_r <= '0;
              dr_r <= dr_r + CNT_W'(1);
            end else begin
              dc_r <= dc_r + COL_IDX_W'(1);
            end
          end
          if (issue) begin
            k_r <= k_r + CNT_W'(1);
            if (is_last) begin
              state_r <= ST_LOAD;
            end
          end
        end
        default: state_r <= ST_LOAD;
      endcase

      // read-data holding stage and output register
      if (issue) begin
        pend_r      <= 1'b1;
        pend_last_r <= is_last;
        pend_drop_r <= is_last && drop_r;
      end else if (move) begin
        pend_r <= 1'b0;
      end

      if (move) begin
        out_valid_r <= 1'b1;
        out_byte_r  <= fold_byte;
        out_last_r  <= pend_last_r;
        out_drop_r  <= pend_drop_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_drop_r;

  a_write_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && stored) |-> (state_r == ST_LOAD))
    else $error("store write outside load");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (k_r < n_r))
    else $error("emission ran past message length");

  a_rem_below_l: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SETUP) |-> (div_rem_r < l_eff))
    else $error("remainder not below column count");

  a_pend_held: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && out_valid_r && !out_tready) |=> (pend_r && $stable(rd_data)))
    else $error("held read data lost");

  a_last_ends_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && is_last) |=> (state_r == ST_LOAD))
    else $error("emission did not end on last read");

endmodule

/* sim/testbench.sv */
// Self-checking bench for columnar_transposition: streams messages in both directions
// under changing key settings and compares every output byte with a built-in predictor.
// Depends on colt_pkg and the columnar_transposition RTL.
module testbench;

  localparam int BW          = colt_pkg::BYTE_W;
  localparam int KW          = colt_pkg::KEYLEN_W;
  localparam int RW          = colt_pkg::RANK_W;
  localparam int MSG_CAP     = colt_pkg::MAX_BYTES_DEF;
  localparam int COL_CAP     = colt_pkg::MAX_COLUMNS_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_PAUSE = 40;

  typedef struct packed {
    logic [BW-1:0] data;
    logic          last;
  } msg_byte_t;

  typedef struct packed {
    logic [BW-1:0] data;
    logic          last;
    logic          dropped;
  } cipher_byte_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [colt_pkg::CFG_IDX_W-1:0] cfg_index = colt_pkg::REG_DIRECTION;
  logic [RW-1:0]                  cfg_data = '0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [BW-1:0]                  in_tdata = '0;
  logic                           in_tlast = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [BW-1:0]                  out_tdata;
  logic                           out_tlast;
  logic                           out_tuser;

  columnar_transposition DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  msg_byte_t    msg_feed[$];
  msg_byte_t    feed_head;
  cipher_byte_t transposed_due[$];
  int           mismatches = 0;
  int           idle_mode = 0;
  int           hold_req = 0;
  int           hold_ack = 0;
  int           hold_left = 0;
  int           quiet_cycles = 0;

  // predictor copy of the key registers and the message buffer
  logic          key_dir = colt_pkg::DIR_ENCRYPT;
  logic [KW-1:0] key_len = colt_pkg::KEYLEN_RESET;
  logic [RW-1:0] key_rank = colt_pkg::RANK_RESET;
  logic [BW-1:0] msg_buf[MSG_CAP];
  int unsigned   msg_len = 0;
  logic          msg_overflow = 1'b0;

  function automatic int tx_idle_pct();
    case (idle_mode)
      0: return 29;
      1: return 68;
      default: return 0;
    endcase
  endfunction

  function automatic int rx_idle_pct();
    case (idle_mode)
      0: return 68;
      1: return 29;
      default: return 0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 100)
      $display("mismatch: %s got %0h want %0h", what, got, want);
    mismatches++;
  endtask

  task automatic transpose_accept(input logic [BW-1:0] b, input logic last);
    int unsigned  cols, n, full, rem, nord, k, pos, len, c, oi, row, rk;
    int unsigned  order[COL_CAP];
    logic [BW-1:0] res[MSG_CAP];
    logic [BW-1:0] v;
    cipher_byte_t item;
    if (msg_len < MSG_CAP) begin
      msg_buf[msg_len] = b;
      msg_len++;
    end else begin
      msg_overflow = 1'b1;
    end
    if (!last) return;
    n = msg_len;
    cols = key_len;
    if (cols < 1) cols = 1;
    if (cols > COL_CAP) cols = COL_CAP;
    nord = 0;
    for (rk = 0; rk < 16; rk++)
      for (c = 0; c < cols; c++)
        if (key_rank[4*c +: 4] == rk[3:0]) begin
          order[nord] = c;
          nord++;
        end
    full = n / cols;
    rem = n % cols;
    k = 0;
    for (oi = 0; oi < cols; oi++) begin
      c = order[oi];
      len = full + ((c < rem) ? 1 : 0);
      for (row = 0; row < len; row++) begin
        pos = row * cols + c;
        if (pos < n && k < n) begin
          if (key_dir == colt_pkg::DIR_ENCRYPT) begin
            v = msg_buf[pos];
            if (v >= colt_pkg::CHAR_UPPER_A && v <= colt_pkg::CHAR_UPPER_Z)
              v = v + colt_pkg::CASE_OFFSET;
            res[k] = v;
          end else begin
            res[pos] = msg_buf[k];
          end
          k++;
        end
      end
    end
    for (k = 0; k < n; k++) begin
      item.data = res[k];
      item.last = (k + 1 == n);
      item.dropped = item.last && msg_overflow;
      transposed_due = {transposed_due, item};
    end
    msg_len = 0;
    msg_overflow = 1'b0;
  endtask

  task automatic check_result();
    cipher_byte_t want;
    if (transposed_due.size() == 0) begin
      report_mismatch("unexpected output byte", int'(out_tdata), 0);
    end else begin
      want = transposed_due.pop_front();
      if (out_tdata !== want.data)
        report_mismatch("out_byte", int'(out_tdata), int'(want.data));
      if (out_tlast !== want.last)
        report_mismatch("last_out", int'(out_tlast), int'(want.last));
      if (out_tuser !== want.dropped)
        report_mismatch("dropped", int'(out_tuser), int'(want.dropped));
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (msg_feed.size() != 0 && $urandom_range(99) >= tx_idle_pct()) begin
        feed_head = msg_feed.pop_front();
        in_tdata  <= feed_head.data;
        in_tlast  <= feed_head.last;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct());
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_ack != hold_req) begin
      hold_left <= HOLD_CYCLES;
      hold_ack  <= hold_req;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          colt_pkg::REG_DIRECTION:   key_dir = cfg_data[0];
          colt_pkg::REG_KEY_LENGTH:  key_len = cfg_data[KW-1:0];
          colt_pkg::REG_COLUMN_RANK: key_rank = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) transpose_accept(in_tdata, in_tlast);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("columnar_transposition regression: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [colt_pkg::CFG_IDX_W-1:0] idx, input logic [RW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (msg_feed.size() != 0 || in_tvalid || transposed_due.size() != 0);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic queue_byte(input logic [BW-1:0] b, input logic last);
    msg_byte_t m;
    m.data = b;
    m.last = last;
    msg_feed = {msg_feed, m};
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], i == s.len() - 1);
  endtask

  function automatic logic [BW-1:0] random_char();
    case ($urandom_range(3))
      0: return BW'($urandom_range(255));
      1: return colt_pkg::CHAR_UPPER_A + BW'($urandom_range(25));
      2: return colt_pkg::CHAR_UPPER_A + colt_pkg::CASE_OFFSET + BW'($urandom_range(25));
      default: return ($urandom_range(1) != 0) ? colt_pkg::CHAR_UPPER_A - BW'(1) :
                                                 colt_pkg::CHAR_UPPER_Z + BW'(1);
    endcase
  endfunction

  task automatic queue_message(input int len);
    for (int i = 0; i < len; i++) queue_byte(random_char(), i == len - 1);
  endtask

  function automatic logic [RW-1:0] random_rank_perm();
    logic [3:0]    nib[16];
    logic [3:0]    t;
    logic [RW-1:0] r;
    int            j;
    for (int i = 0; i < 16; i++) nib[i] = i[3:0];
    for (int i = 15; i > 0; i--) begin
      j = $urandom_range(i);
      t = nib[i];
      nib[i] = nib[j];
      nib[j] = t;
    end
    r = '0;
    for (int i = 0; i < 16; i++) r[4*i +: 4] = nib[i];
    return r;
  endfunction

  initial begin
    int            batch_bytes;
    int            len;
    logic [KW-1:0] kl;
    logic [RW-1:0] rank;
    logic          dir;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset key: encrypt, sixteen columns, identity order; case-fold boundaries
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(colt_pkg::CHAR_UPPER_A, 1'b0);
    queue_byte(colt_pkg::CHAR_UPPER_Z, 1'b0);
    queue_byte(colt_pkg::CHAR_UPPER_A - BW'(1), 1'b0);
    queue_byte(colt_pkg::CHAR_UPPER_Z + BW'(1), 1'b0);
    queue_byte(8'h61, 1'b1);
    wait_drained();

    // decrypt with short columns
    write_reg(colt_pkg::REG_DIRECTION, RW'(colt_pkg::DIR_DECRYPT));
    write_reg(colt_pkg::REG_KEY_LENGTH, RW'(3));
    write_reg(colt_pkg::REG_COLUMN_RANK, 64'h102);
    send_text("ACEGBDF");
    wait_drained();

    // zero key length acts as one column
    write_reg(colt_pkg::REG_DIRECTION, RW'(colt_pkg::DIR_ENCRYPT));
    write_reg(colt_pkg::REG_KEY_LENGTH, RW'(0));
    send_text("QrS");
    wait_drained();

    // oversized key length, all ranks tied
    write_reg(colt_pkg::REG_DIRECTION, RW'(colt_pkg::DIR_DECRYPT));
    write_reg(colt_pkg::REG_KEY_LENGTH, RW'(31));
    write_reg(colt_pkg::REG_COLUMN_RANK, {RW{1'b1}});
    send_text("tRaNs");
    wait_drained();

    for (int b = 0; b < 6; b++) begin
      idle_mode = b / 2;
      dir = (b < 4) ? b[0] : 1'($urandom_range(1));
      case (b)
        0: kl = KW'(1);
        1: kl = KW'(16);
        5: kl = KW'(17 + $urandom_range(14));
        default: kl = KW'($urandom_range(2, 15));
      endcase
      case (b)
        1: rank = '0;
        3: rank = {$urandom, $urandom};
        default: rank = random_rank_perm();
      endcase
      write_reg(colt_pkg::REG_DIRECTION, RW'(dir));
      write_reg(colt_pkg::REG_KEY_LENGTH, RW'(kl));
      write_reg(colt_pkg::REG_COLUMN_RANK, rank);
      if (b == 4) begin
        hold_req++;
        queue_message(66);
      end
      batch_bytes = 0;
      while (batch_bytes < 8) begin
        len = ($urandom_range(15) == 0) ? $urandom_range(56, 70) : $urandom_range(1, 12);
        queue_message(len);
        batch_bytes += len;
      end
      wait_drained();
    end

    if (mismatches == 0)
      $display("columnar_transposition regression: pass");
    else
      $display("columnar_transposition regression: fail");
    $finish;
  end

endmodule
